@@ rtl/armw_pkg.sv @@
// ----------------------------------------------------------------------------
// armw_pkg
// shared types and constants of the atomic read-modify-write unit
// ----------------------------------------------------------------------------
package armw_pkg;

    localparam int unsigned WordCountDefault = 1024;
    localparam int unsigned WordBits = 64;

    typedef enum logic [3:0] {
        MODE_CAS    = 4'd0,
        MODE_CMP    = 4'd1,
        MODE_AND    = 4'd2,
        MODE_OR     = 4'd3,
        MODE_XOR    = 4'd4,
        MODE_ADD    = 4'd5,
        MODE_SUB    = 4'd6,
        MODE_MUL    = 4'd7,
        MODE_DIV    = 4'd8,
        MODE_NOT    = 4'd9,
        MODE_INC    = 4'd10,
        MODE_DEC    = 4'd11,
        MODE_SWAP   = 4'd12,
        MODE_REDUCE = 4'd13
    } t_mode;

    typedef enum logic [7:0] {
        SEL_SUM  = 8'd0,
        SEL_SMIN = 8'd1,
        SEL_SMAX = 8'd2,
        SEL_AND  = 8'd3,
        SEL_OR   = 8'd4,
        SEL_XOR  = 8'd5
    } t_sel;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_MISALIGNED = 3'd1,
        ST_DIV_ZERO   = 3'd2,
        ST_DIV_OVF    = 3'd3,
        ST_BAD_SEL    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV,
        S_WRITE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [3:0]  mode;
        logic [12:0] address;
        logic [63:0] operand;
        logic [63:0] expected;
        logic [7:0]  reduce_select;
    } t_req;

    typedef struct packed {
        logic [63:0] old_value;
        logic        reg_write;
        logic [63:0] compare_diff;
        logic        compare_valid;
        logic [2:0]  status;
    } t_rsp;

endpackage

@@ rtl/armw_if.sv @@
// ----------------------------------------------------------------------------
// armw_req_if / armw_rsp_if
// valid/ready channels for requests and responses
// ----------------------------------------------------------------------------
interface armw_req_if;
    logic              valid;
    logic              ready;
    armw_pkg::t_req    payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface armw_rsp_if;
    logic              valid;
    logic              ready;
    armw_pkg::t_rsp    payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/atomic_read_modify_write_unit_top.sv @@
// ----------------------------------------------------------------------------
// atomic_read_modify_write_unit_top
// atomic operations on a single-port word memory
// ----------------------------------------------------------------------------
// After reset the unit clears the memory, one word a cycle, over all WORD_COUNT
// words, and accepts no request meanwhile. One request is handled at a time:
// the word is read in the transfer cycle, modified, written back unless it is
// a compare or a failed CAS, then the response is held in an output register.
// Errors go from the read state straight to the output state, mul adds up
// three 32x32 partial products and signed div runs a radix-2 iterative
// divider, one quotient bit a cycle. Errors skip the write.
module atomic_read_modify_write_unit_top #(
    parameter int unsigned WORD_COUNT = armw_pkg::WordCountDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    armw_req_if.sink   i_req,
    armw_rsp_if.source o_rsp
);
    import armw_pkg::*;

    localparam int unsigned IdxW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam logic [31:0] IdxRecip = 32'((64'd1 << 20) / WORD_COUNT);

    logic [63:0] r_mem [WORD_COUNT];
    logic [63:0] r_rdata;

    t_state      r_state, n_state;
    t_req        r_req;
    logic [IdxW:0] r_clr, n_clr;
    logic [IdxW-1:0] w_idx;
    logic [IdxW-1:0] w_req_idx;
    logic [63:0] r_new, n_new;
    t_rsp        r_rsp, n_rsp;
    logic        r_wr, n_wr;
    logic [1:0]  r_mstep, n_mstep;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_quo, n_quo;
    logic [64:0] r_rem, n_rem;
    logic [63:0] r_dvs, n_dvs;
    logic [6:0]  r_dcnt, n_dcnt;
    logic        r_qneg, n_qneg;

    logic        w_mem_we;
    logic [IdxW-1:0] w_mem_addr;
    logic [63:0] w_mem_wdata;
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    logic [64:0] w_sub;

    // word number modulo WORD_COUNT by reciprocal multiply and one correction
    function automatic logic [IdxW-1:0] word_index(logic [9:0] x);
        logic [31:0] q;
        logic [31:0] r;
        q = (32'(x) * IdxRecip) >> 20;
        r = 32'(x) - q * 32'(WORD_COUNT);
        if (r >= 32'(WORD_COUNT)) r = r - 32'(WORD_COUNT);
        return IdxW'(r);
    endfunction

    assign w_idx     = word_index(r_req.address[12:3]);
    assign w_req_idx = word_index(i_req.payload.address[12:3]);

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        r_rdata <= r_mem[w_mem_addr];
    end

    always_comb begin
        w_mem_we    = (r_state == S_CLEAR) || (r_state == S_WRITE && r_wr);
        w_mem_addr  = (r_state == S_CLEAR) ? r_clr[IdxW-1:0]
                    : (r_state == S_IDLE)  ? w_req_idx : w_idx;
        w_mem_wdata = (r_state == S_CLEAR) ? '0 : r_new;
    end

    always_comb begin
        case (r_mstep)
            2'd0:    begin w_ma = r_rdata[31:0];  w_mb = r_req.operand[31:0];  end
            2'd1:    begin w_ma = r_rdata[63:32]; w_mb = r_req.operand[31:0];  end
            2'd2:    begin w_ma = r_rdata[31:0];  w_mb = r_req.operand[63:32]; end
            default: begin w_ma = r_rdata[31:0];  w_mb = r_req.operand[31:0];  end
        endcase
        w_prod = 64'(w_ma) * 64'(w_mb);
        w_sub  = {r_rem[63:0], r_quo[63]} - {1'b0, r_dvs};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == (IdxW+1)'(WORD_COUNT - 1)) n_state = S_IDLE;
            S_IDLE:  if (i_req.valid) n_state = S_READ;
            S_READ: begin
                if (r_req.mode > MODE_REDUCE || r_req.address[2:0] != 3'd0
                    || n_rsp.status != ST_OK) begin
                    n_state = S_OUT;
                end else if (r_req.mode == MODE_MUL) begin
                    n_state = S_MUL;
                end else if (r_req.mode == MODE_DIV) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_MUL:   if (r_mstep == 2'd2) n_state = S_WRITE;
            S_DIV:   if (r_dcnt == 7'd0) n_state = S_WRITE;
            S_WRITE: n_state = S_OUT;
            S_OUT:   if (o_rsp.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_clr   = r_clr;
        n_new   = r_new;
        n_rsp   = r_rsp;
        n_wr    = r_wr;
        n_mstep = r_mstep;
        n_acc   = r_acc;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_dcnt  = r_dcnt;
        n_qneg  = r_qneg;
        case (r_state)
            S_CLEAR: n_clr = r_clr + 1'b1;
            S_READ: begin
                n_rsp = '0;
                n_wr  = 1'b0;
                n_mstep = 2'd0;
                n_acc = '0;
                if (r_req.mode > MODE_REDUCE) begin
                    n_rsp = '0;
                end else if (r_req.address[2:0] != 3'd0) begin
                    n_rsp.status = ST_MISALIGNED;
                end else begin
                    n_rsp.old_value = r_rdata;
                    n_rsp.reg_write = 1'b1;
                    n_wr = 1'b1;
                    case (t_mode'(r_req.mode))
                        MODE_CAS: begin
                            n_new = r_req.operand;
                            n_wr  = (r_rdata == r_req.expected);
                            n_rsp.reg_write = !n_wr;
                        end
                        MODE_CMP: begin
                            n_wr = 1'b0;
                            n_rsp.reg_write = 1'b0;
                            n_rsp.compare_diff = r_rdata - r_req.operand;
                            n_rsp.compare_valid = 1'b1;
                        end
                        MODE_AND:  n_new = r_rdata & r_req.operand;
                        MODE_OR:   n_new = r_rdata | r_req.operand;
                        MODE_XOR:  n_new = r_rdata ^ r_req.operand;
                        MODE_ADD:  n_new = r_rdata + r_req.operand;
                        MODE_SUB:  n_new = r_rdata - r_req.operand;
                        MODE_MUL:  n_new = '0;
                        MODE_DIV: begin
                            if (r_req.operand == '0) begin
                                n_rsp = '0;
                                n_rsp.status = ST_DIV_ZERO;
                                n_wr = 1'b0;
                            end else if (r_rdata == 64'h8000_0000_0000_0000
                                         && r_req.operand == '1) begin
                                n_rsp = '0;
                                n_rsp.status = ST_DIV_OVF;
                                n_wr = 1'b0;
                            end
                            n_quo  = r_rdata[63] ? (64'd0 - r_rdata) : r_rdata;
                            n_dvs  = r_req.operand[63] ? (64'd0 - r_req.operand)
                                                       : r_req.operand;
                            n_rem  = '0;
                            n_dcnt = 7'd64;
                            n_qneg = r_rdata[63] ^ r_req.operand[63];
                        end
                        MODE_NOT: begin
                            n_new = ~r_rdata;
                            n_rsp.reg_write = 1'b0;
                        end
                        MODE_INC: begin
                            n_new = r_rdata + 64'd1;
                            n_rsp.reg_write = 1'b0;
                        end
                        MODE_DEC: begin
                            n_new = r_rdata - 64'd1;
                            n_rsp.reg_write = 1'b0;
                        end
                        MODE_SWAP: n_new = r_req.operand;
                        MODE_REDUCE: begin
                            case (t_sel'(r_req.reduce_select))
                                SEL_SUM:  n_new = r_rdata + r_req.operand;
                                SEL_SMIN: n_new = ($signed(r_req.operand) < $signed(r_rdata))
                                                  ? r_req.operand : r_rdata;
                                SEL_SMAX: n_new = ($signed(r_rdata) < $signed(r_req.operand))
                                                  ? r_req.operand : r_rdata;
                                SEL_AND:  n_new = r_rdata & r_req.operand;
                                SEL_OR:   n_new = r_rdata | r_req.operand;
                                SEL_XOR:  n_new = r_rdata ^ r_req.operand;
                                default: begin
                                    n_rsp = '0;
                                    n_rsp.status = ST_BAD_SEL;
                                    n_wr = 1'b0;
                                end
                            endcase
                        end
                        default: n_rsp = '0;
                    endcase
                end
            end
            S_MUL: begin
                n_mstep = r_mstep + 2'd1;
                case (r_mstep)
                    2'd0:    n_acc = r_acc + w_prod;
                    default: n_acc = r_acc + {w_prod[31:0], 32'd0};
                endcase
                if (r_mstep == 2'd2) n_new = n_acc;
            end
            S_DIV: begin
                if (r_dcnt != 7'd0) begin
                    n_dcnt = r_dcnt - 7'd1;
                    if (!w_sub[64]) begin
                        n_rem = {1'b0, w_sub[63:0]};
                        n_quo = {r_quo[62:0], 1'b1};
                    end else begin
                        n_rem = {1'b0, r_rem[62:0], r_quo[63]};
                        n_quo = {r_quo[62:0], 1'b0};
                    end
                end else begin
                    n_new = r_qneg ? (64'd0 - r_quo) : r_quo;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
        if (r_state == S_IDLE && i_req.valid) r_req <= i_req.payload;
        r_new   <= n_new;
        r_rsp   <= n_rsp;
        r_wr    <= n_wr;
        r_mstep <= n_mstep;
        r_acc   <= n_acc;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_dvs   <= n_dvs;
        r_dcnt  <= n_dcnt;
        r_qneg  <= n_qneg;
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = (r_state == S_OUT);
    assign o_rsp.payload = r_rsp;

endmodule

@@ rtl/armw_checker.sv @@
// ----------------------------------------------------------------------------
// armw_checker
// port-level checks of the atomic read-modify-write unit
// ----------------------------------------------------------------------------
module armw_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_ready,
    input logic           o_rsp_valid,
    input logic           o_rsp_ready,
    input armw_pkg::t_rsp o_rsp_payload
);
    import armw_pkg::*;

    // one item in flight
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req_ready && o_rsp_valid)) else $error("ready while response pending");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |=> o_rsp_valid && $stable(o_rsp_payload))
        else $error("response dropped or changed");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp_payload.status != ST_OK |->
        o_rsp_payload.old_value == '0 && !o_rsp_payload.reg_write
        && !o_rsp_payload.compare_valid) else $error("error response not clean");

    a_diff_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_payload.compare_valid |->
        o_rsp_payload.compare_diff == '0) else $error("stray compare result");

    a_cmp_noreg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp_payload.compare_valid |-> !o_rsp_payload.reg_write)
        else $error("compare writes register");

endmodule

bind atomic_read_modify_write_unit_top armw_checker u_armw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_ready  (i_req.ready),
    .o_rsp_valid  (o_rsp.valid),
    .o_rsp_ready  (o_rsp.ready),
    .o_rsp_payload(o_rsp.payload)
);
